>>> hw/rtl/cwrc_pkg.sv
package cwrc_pkg;

  // request kinds as carried in s_tuser
  typedef enum logic [1:0] {
    REQ_RTT     = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [2:0] CFG_INITIAL_WINDOW  = 3'd0;
  localparam logic [2:0] CFG_MIN_WINDOW      = 3'd1;
  localparam logic [2:0] CFG_MAX_WINDOW      = 3'd2;
  localparam logic [2:0] CFG_INITIAL_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_MIN_TIMEOUT     = 3'd4;
  localparam logic [2:0] CFG_MAX_TIMEOUT     = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT_LIMIT   = 3'd6;
  localparam logic [2:0] CFG_DUPACK_THRESH   = 3'd7;

  // register reset values
  localparam logic [15:0] RST_INITIAL_WINDOW  = 16'd10;
  localparam logic [15:0] RST_MIN_WINDOW      = 16'd2;
  localparam logic [15:0] RST_MAX_WINDOW      = 16'd4096;
  localparam logic [31:0] RST_INITIAL_TIMEOUT = 32'd1000000;
  localparam logic [31:0] RST_MIN_TIMEOUT     = 32'd200000;
  localparam logic [31:0] RST_MAX_TIMEOUT     = 32'd60000000;
  localparam logic [7:0]  RST_TIMEOUT_LIMIT   = 8'd10;
  localparam logic [6:0]  RST_DUPACK_THRESH   = 7'd3;

  localparam logic [7:0]  RUN_SAT = 8'hff;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] min_window;
    logic [15:0] max_window;
    logic [31:0] min_timeout;
    logic [31:0] max_timeout;
    logic [7:0]  timeout_limit;
  } cfg_t;

  // classified command between front and back
  typedef struct packed {
    req_t        kind;
    logic [31:0] value;    // rtt sample or gap age
    logic [10:0] acked;    // saturated ack count
    logic        dup_hit;  // marks past gap reach threshold and gap pending
  } cmd_t;

endpackage

>>> hw/rtl/congestion_window_rto_controller.sv
// queue head to m_tvalid: rtt via RTT, RTO, OUT; timeout via TMO, OUT; unknown via OUT
// ack report: one ACK step per acked packet, then CAP, FR and OUT, plus a DIV wait
//   each time the window changes in congestion avoidance (reciprocal divider)
// throughput: one request at a time in the back end, a 2-entry queue ahead of it
// reset: synchronous rst restores registers and state to defaults, clears queue
module congestion_window_rto_controller
  import cwrc_pkg::*;
#(
  parameter int FRACTION_BITS        = 16,
  parameter int MAX_ACKED_PER_REPORT = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rtt_sample_us, newly_acked, acked_beyond_gap, gap_pending, gap_age_us, zero pad
  input  logic [87:0]  s_tdata,
  // req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // window_q16, threshold_q16, timeout_us, srtt_us
  output logic [127:0] m_tdata,
  // fast_retransmit, peer_lost
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t        cfg;
  logic [6:0]  dupack_threshold;
  logic        f_valid;
  logic        f_ready;
  cmd_t        f_cmd;
  logic        q_valid;
  logic        q_ready;
  cmd_t        q_cmd;

  // configuration registers, initial window and timeout are fixed reset values and ignore writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_window    <= RST_MIN_WINDOW;
      cfg.max_window    <= RST_MAX_WINDOW;
      cfg.min_timeout   <= RST_MIN_TIMEOUT;
      cfg.max_timeout   <= RST_MAX_TIMEOUT;
      cfg.timeout_limit <= RST_TIMEOUT_LIMIT;
      dupack_threshold  <= RST_DUPACK_THRESH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_WINDOW:    cfg.min_window    <= cfg_data[15:0];
        CFG_MAX_WINDOW:    cfg.max_window    <= cfg_data[15:0];
        CFG_MIN_TIMEOUT:   cfg.min_timeout   <= cfg_data;
        CFG_MAX_TIMEOUT:   cfg.max_timeout   <= cfg_data;
        CFG_TIMEOUT_LIMIT: cfg.timeout_limit <= cfg_data[7:0];
        CFG_DUPACK_THRESH: dupack_threshold  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  cwrc_front #(.MAX_ACKED_PER_REPORT(MAX_ACKED_PER_REPORT)) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .req_type         (s_tuser),
    .rtt_sample_us    (s_tdata[31:0]),
    .newly_acked      (s_tdata[42:32]),
    .acked_beyond_gap (s_tdata[49:43]),
    .gap_pending      (s_tdata[50]),
    .gap_age_us       (s_tdata[82:51]),
    .dupack_threshold (dupack_threshold),
    .cmd_valid        (f_valid),
    .cmd_ready        (f_ready),
    .cmd              (f_cmd)
  );

  cwrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  cwrc_back #(.FB(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

>>> hw/rtl/cwrc_front.sv
module cwrc_front
  import cwrc_pkg::*;
#(
  parameter int MAX_ACKED_PER_REPORT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] rtt_sample_us,
  input  logic [10:0] newly_acked,
  input  logic [6:0]  acked_beyond_gap,
  input  logic        gap_pending,
  input  logic [31:0] gap_age_us,
  input  logic [6:0]  dupack_threshold,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [16:0] MAX_A = 17'(MAX_ACKED_PER_REPORT);

  cmd_t cmd_in;
  logic valid;

  // classify the incoming request
  always_comb begin
    cmd_in.kind  = req_t'(req_type);
    cmd_in.value = (req_type == REQ_RTT) ? rtt_sample_us : gap_age_us;
    if ({6'd0, newly_acked} > MAX_A) begin
      cmd_in.acked = MAX_A[10:0];
    end else begin
      cmd_in.acked = newly_acked;
    end
    cmd_in.dup_hit = (acked_beyond_gap >= dupack_threshold) && gap_pending;
  end

  assign in_ready  = !valid || cmd_ready;
  assign cmd_valid = valid;

  // one staging register ahead of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd <= cmd_in;
    end
  end

endmodule

>>> hw/rtl/cwrc_queue.sv
module cwrc_queue
  import cwrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/cwrc_recip.sv
module cwrc_recip #(
  parameter int FB = 16,
  parameter int WW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WW-1:0] divisor,
  output logic          done,
  output logic [FB:0]   quotient
);

  localparam int CW = $clog2(2 * FB + 1);
  localparam logic [CW-1:0] STEPS = CW'(2 * FB);

  logic [WW-1:0] rem;
  logic [WW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [WW:0]   rem_s;
  logic [WW:0]   diff;

  // restoring division of 2^(2*FB) by the divisor, one bit a cycle
  assign rem_s = {rem, 1'b0};
  assign diff  = rem_s - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // leading dividend bit already shifted in, divisor exceeds it
      rem      <= WW'(1);
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (!diff[WW]) begin
        rem      <= diff[WW-1:0];
        quotient <= {quotient[FB-1:0], 1'b1};
      end else begin
        rem      <= rem_s[WW-1:0];
        quotient <= {quotient[FB-1:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/cwrc_back.sv
module cwrc_back
  import cwrc_pkg::*;
#(
  parameter int FB = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_data,
  output logic [1:0]   out_user
);

  localparam int WW = FB + 17;
  localparam logic [WW-1:0] ONE_W = {{(WW - 1){1'b0}}, 1'b1} << FB;
  localparam logic [FB:0]   ONE_F = {1'b1, {FB{1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RTT  = 9'b000000010,
    ST_RTO  = 9'b000000100,
    ST_TMO  = 9'b000001000,
    ST_ACK  = 9'b000010000,
    ST_DIV  = 9'b000100000,
    ST_CAP  = 9'b001000000,
    ST_FR   = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t        state;
  cmd_t          cur;
  logic [10:0]   cnt;
  logic [WW-1:0] window;
  logic [WW-1:0] threshold;
  logic [FB:0]   fraction;
  logic [FB:0]   recip;
  logic          recip_ok;
  logic [31:0]   srtt;
  logic [31:0]   rttvar;
  logic [31:0]   rto;
  logic [7:0]    run;
  logic          fr;
  logic          lost;

  logic          div_start;
  logic          div_done;
  logic [FB:0]   div_q;

  logic [WW-1:0] min_q;
  logic [WW-1:0] max_q;
  logic [WW-1:0] half_floor;
  logic [31:0]   diff;
  logic [34:0]   var_sum;
  logic [34:0]   srtt_sum;
  logic [34:0]   rto_sum;
  logic [34:0]   rto_lo;
  logic [32:0]   rto_dbl;
  logic [FB+1:0] frac_sum;
  logic [7:0]    run_inc;

  assign min_q      = {1'b0, cfg.min_window, {FB{1'b0}}};
  assign max_q      = {1'b0, cfg.max_window, {FB{1'b0}}};
  assign half_floor = ((window >> 1) > min_q) ? (window >> 1) : min_q;
  assign diff       = (cur.value > srtt) ? (cur.value - srtt) : (srtt - cur.value);
  assign var_sum    = {1'b0, rttvar, 2'b0} - {3'b0, rttvar} + {3'b0, diff};
  assign srtt_sum   = {srtt, 3'b0} - {3'b0, srtt} + {3'b0, cur.value};
  assign rto_sum    = {3'b0, srtt} + {1'b0, rttvar, 2'b0};
  assign rto_lo     = (rto_sum < {3'b0, cfg.min_timeout}) ? {3'b0, cfg.min_timeout} : rto_sum;
  assign rto_dbl    = {rto, 1'b0};
  assign frac_sum   = {1'b0, fraction} + {1'b0, recip};
  assign run_inc    = (run == RUN_SAT) ? run : run + 8'd1;

  assign cmd_ready  = (state == ST_IDLE);
  assign div_start  = (state == ST_ACK) && (cnt != 11'd0) && !(window < threshold)
                      && !recip_ok && (window > ONE_W);

  cwrc_recip #(.FB(FB), .WW(WW)) u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (window),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and sender state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      window    <= {1'b0, RST_INITIAL_WINDOW, {FB{1'b0}}};
      threshold <= {1'b0, RST_MAX_WINDOW, {FB{1'b0}}};
      fraction  <= '0;
      recip_ok  <= 1'b0;
      srtt      <= '0;
      rttvar    <= '0;
      rto       <= RST_INITIAL_TIMEOUT;
      run       <= '0;
      fr        <= 1'b0;
      lost      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            fr   <= 1'b0;
            lost <= 1'b0;
            case (cmd.kind)
              REQ_RTT:     state <= ST_RTT;
              REQ_TIMEOUT: state <= ST_TMO;
              REQ_ACK: begin
                if (cmd.acked != 11'd0) run <= '0;
                state <= ST_ACK;
              end
              default:     state <= ST_OUT;
            endcase
          end
        end
        // estimator update, first sample seeds it
        ST_RTT: begin
          if (srtt == 32'd0) begin
            srtt   <= cur.value;
            rttvar <= {1'b0, cur.value[31:1]};
          end else begin
            rttvar <= var_sum[33:2];
            srtt   <= srtt_sum[34:3];
          end
          state <= ST_RTO;
        end
        // clamp, the upper bound wins
        ST_RTO: begin
          rto   <= (rto_lo > {3'b0, cfg.max_timeout}) ? cfg.max_timeout : rto_lo[31:0];
          state <= ST_OUT;
        end
        ST_TMO: begin
          run <= run_inc;
          if (run_inc > cfg.timeout_limit) begin
            lost <= 1'b1;
          end else begin
            threshold <= half_floor;
            window    <= min_q;
            fraction  <= '0;
            recip_ok  <= 1'b0;
            rto       <= (rto_dbl < {1'b0, cfg.max_timeout}) ? rto_dbl[31:0] : cfg.max_timeout;
          end
          state <= ST_OUT;
        end
        // one acked packet a cycle, unless the reciprocal is being recomputed
        ST_ACK: begin
          if (cnt == 11'd0) begin
            state <= ST_CAP;
          end else if (window < threshold) begin
            window   <= window + ONE_W;
            recip_ok <= 1'b0;
          end else if (!recip_ok) begin
            if (window > ONE_W) begin
              state <= ST_DIV;
            end else begin
              recip    <= ONE_F;
              recip_ok <= 1'b1;
            end
          end else if (frac_sum >= {1'b0, ONE_F}) begin
            window   <= window + ONE_W;
            fraction <= (FB + 1)'(frac_sum - {1'b0, ONE_F});
            recip_ok <= 1'b0;
          end else begin
            fraction <= frac_sum[FB:0];
          end
        end
        ST_DIV: begin
          if (div_done) begin
            recip    <= div_q;
            recip_ok <= 1'b1;
            state    <= ST_ACK;
          end
        end
        ST_CAP: begin
          if (window > max_q) begin
            window   <= max_q;
            recip_ok <= 1'b0;
          end
          fr    <= cur.dup_hit && (cur.value > {1'b0, srtt[31:1]});
          state <= ST_FR;
        end
        // multiplicative decrease on fast retransmit
        ST_FR: begin
          if (fr) begin
            threshold <= half_floor;
            window    <= half_floor;
            fraction  <= '0;
            recip_ok  <= 1'b0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per packet down counter and command hold
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      cur <= cmd;
      cnt <= cmd.acked;
    end else if (state == ST_ACK && cnt != 11'd0 && (window < threshold ||
                 (recip_ok))) begin
      cnt <= cnt - 11'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_data <= {srtt, rto, 32'(threshold), 32'(window)};
      out_user <= {lost, fr};
    end
  end

endmodule

>>> hw/rtl/cwrc_checker.sv
module cwrc_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [1:0]   m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // the two flags come from different requests
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("fast retransmit and peer lost together");

  // fast retransmit sets window to threshold
  a_fr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == m_tdata[63:32])
    else $error("window differs from threshold after fast retransmit");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind congestion_window_rto_controller cwrc_checker u_cwrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/tb.sv
module tb;
  import cwrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int ACK_CAP = 1024;
  localparam int STALL_LIMIT = 200000;

  // one event toward the controller
  typedef struct {
    req_t        kind;
    logic [31:0] rtt;
    logic [10:0] acked;
    logic [6:0]  beyond;
    logic        gap;
    logic [31:0] age;
    int unsigned pause;
    bit          drain;
  } event_t;

  // sender state reported after one event
  typedef struct {
    logic [31:0] win;
    logic [31:0] thr;
    logic [31:0] rto;
    logic [31:0] srtt;
    bit          fr;
    bit          lost;
  } report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [87:0]  s_tdata = '0;
  logic [1:0]   s_tuser = REQ_NONE;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = CFG_INITIAL_WINDOW;
  logic [31:0]  cfg_data = '0;

  congestion_window_rto_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // events waiting to be sent and reports still owed by the controller
  event_t  event_q[$];
  report_t report_q[$];

  int unsigned mismatches = 0;
  int unsigned n_rtt = 0, n_ack = 0, n_tmo = 0, n_none = 0;
  int unsigned n_fr = 0, n_lost = 0, n_reports = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;

  // shadow configuration, live registers only
  logic [63:0] min_win_c = 64'(RST_MIN_WINDOW);
  logic [63:0] max_win_c = 64'(RST_MAX_WINDOW);
  logic [63:0] min_rto_c = 64'(RST_MIN_TIMEOUT);
  logic [63:0] max_rto_c = 64'(RST_MAX_TIMEOUT);
  logic [63:0] to_limit_c = 64'(RST_TIMEOUT_LIMIT);
  logic [63:0] dupack_c = 64'(RST_DUPACK_THRESH);

  // shadow sender state, taken from the register defaults at reset
  logic [63:0] cwnd = 64'(RST_INITIAL_WINDOW) << FRAC;
  logic [63:0] ssthresh = 64'(RST_MAX_WINDOW) << FRAC;
  logic [63:0] cwnd_frac = '0;
  logic [63:0] srtt = '0;
  logic [63:0] rttvar = '0;
  logic [63:0] rto = 64'(RST_INITIAL_TIMEOUT);
  logic [63:0] to_run = '0;

  function automatic logic [63:0] halved_window();
    logic [63:0] half;
    logic [63:0] floor_q;
    half = cwnd >> 1;
    floor_q = min_win_c << FRAC;
    return (half > floor_q) ? half : floor_q;
  endfunction

  // advance the shadow state by one event and return the report it yields
  function automatic report_t advance_sender(input event_t e);
    report_t     r;
    logic [63:0] n, d, recip, cand;
    r.fr = 1'b0;
    r.lost = 1'b0;
    case (e.kind)
      REQ_RTT: begin
        if (srtt == 0) begin
          srtt = 64'(e.rtt);
          rttvar = 64'(e.rtt) >> 1;
        end else begin
          d = (64'(e.rtt) > srtt) ? 64'(e.rtt) - srtt : srtt - 64'(e.rtt);
          rttvar = (3 * rttvar + d) >> 2;
          srtt = (7 * srtt + 64'(e.rtt)) >> 3;
        end
        rttvar &= 64'hffff_ffff;
        srtt &= 64'hffff_ffff;
        cand = srtt + 4 * rttvar;
        if (cand < min_rto_c) cand = min_rto_c;
        if (cand > max_rto_c) cand = max_rto_c;
        rto = cand;
      end
      REQ_ACK: begin
        n = (e.acked > ACK_CAP) ? ACK_CAP : 64'(e.acked);
        if (n > 0) to_run = 0;
        for (int i = 0; i < n; i++) begin
          if (cwnd < ssthresh) begin
            cwnd += 64'd1 << FRAC;
          end else begin
            recip = 64'd1 << FRAC;
            if (cwnd > (64'd1 << FRAC)) recip = (64'd1 << (2 * FRAC)) / cwnd;
            cwnd_frac += recip;
            if (cwnd_frac >= (64'd1 << FRAC)) begin
              cwnd += 64'd1 << FRAC;
              cwnd_frac -= 64'd1 << FRAC;
            end
          end
        end
        if (cwnd > (max_win_c << FRAC)) cwnd = max_win_c << FRAC;
        if (64'(e.beyond) >= dupack_c && e.gap && 64'(e.age) > (srtt >> 1)) begin
          ssthresh = halved_window();
          cwnd = ssthresh;
          cwnd_frac = 0;
          r.fr = 1'b1;
        end
      end
      REQ_TIMEOUT: begin
        if (to_run < 255) to_run++;
        if (to_run > to_limit_c) begin
          r.lost = 1'b1;
        end else begin
          ssthresh = halved_window();
          cwnd = min_win_c << FRAC;
          cwnd_frac = 0;
          cand = rto * 2;
          rto = (cand < max_rto_c) ? cand : max_rto_c;
        end
      end
      default: ;
    endcase
    r.win = cwnd[31:0];
    r.thr = ssthresh[31:0];
    r.rto = rto[31:0];
    r.srtt = srtt[31:0];
    return r;
  endfunction

  // driver: presents queued events, honoring per-event pauses and drains
  int pause_left = -1;
  always @(posedge clk) begin
    logic   vld_n;
    event_t e;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      vld_n = s_tvalid;
      if (s_tvalid && s_tready) begin
        e.kind = req_t'(s_tuser);
        {e.age, e.gap, e.beyond, e.acked, e.rtt} = s_tdata[82:0];
        report_q.insert(report_q.size(), advance_sender(e));
        vld_n = 1'b0;
      end
      if (!vld_n && event_q.size() > 0) begin
        if (pause_left < 0) pause_left = event_q[0].pause;
        if (pause_left > 0) begin
          pause_left--;
        end else if (!event_q[0].drain || report_q.size() == 0) begin
          e = event_q[0];
          event_q.delete(0);
          pause_left = -1;
          s_tdata <= {5'b0, e.age, e.gap, e.beyond, e.acked, e.rtt};
          s_tuser <= e.kind;
          vld_n = 1'b1;
        end
      end
      s_tvalid <= vld_n;
    end
  end

  task automatic flag_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // monitor: checks each report transaction against the oldest prediction
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    report_t want;
    logic    rdy_n;
    if (!rst) begin
      rdy_n = m_tready;
      if (m_tvalid && m_tready) begin
        n_reports++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("report with nothing outstanding: %h", m_tdata);
        end else begin
          want = report_q[0];
          report_q.delete(0);
          flag_field("window", want.win, m_tdata[31:0]);
          flag_field("threshold", want.thr, m_tdata[63:32]);
          flag_field("timeout", want.rto, m_tdata[95:64]);
          flag_field("srtt", want.srtt, m_tdata[127:96]);
          flag_field("fast_retransmit", 32'(want.fr), 32'(m_tuser[0]));
          flag_field("peer_lost", 32'(want.lost), 32'(m_tuser[1]));
          if (want.fr) n_fr++;
          if (want.lost) n_lost++;
        end
        stall_left = rx_idle_on ? $urandom_range(0, 18) : 0;
        rdy_n = (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        rdy_n = (stall_left == 0);
      end else begin
        rdy_n = 1'b1;
      end
      m_tready <= rdy_n;
    end
  end

  // watchdog on cycles without any transaction while work is outstanding
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (event_q.size() == 0 && report_q.size() == 0)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int unsigned draw_pause();
    return (tx_idle_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
  endfunction

  task automatic queue_event(input req_t k, input logic [31:0] rtt_v, input logic [31:0] ack_v,
                             input logic [31:0] beyond_v, input logic [31:0] gap_v,
                             input logic [31:0] age_v);
    event_t e;
    e.kind = k;
    e.rtt = rtt_v;
    e.acked = ack_v[10:0];
    e.beyond = beyond_v[6:0];
    e.gap = gap_v[0];
    e.age = age_v;
    e.pause = draw_pause();
    e.drain = ($urandom_range(0, 49) == 0);
    case (k)
      REQ_RTT: n_rtt++;
      REQ_ACK: n_ack++;
      REQ_TIMEOUT: n_tmo++;
      default: n_none++;
    endcase
    event_q.insert(event_q.size(), e);
  endtask

  // random traffic, mostly plausible acks and samples with timeout bursts
  task automatic queue_random(input int unsigned count);
    int unsigned sel;
    logic [31:0] rtt_v, age_v;
    logic [31:0] ack_v;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      rtt_v = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000000);
      age_v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000000);
      case ($urandom_range(0, 39))
        0: ack_v = $urandom_range(1024, 2047);
        1, 2, 3, 4, 5, 6, 7, 8, 9, 10: ack_v = $urandom_range(0, 300);
        default: ack_v = $urandom_range(0, 40);
      endcase
      if (sel < 28) begin
        queue_event(REQ_RTT, rtt_v, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 75) begin
        queue_event(REQ_ACK, $urandom, ack_v, $urandom_range(0, 127), $urandom, age_v);
      end else if (sel < 80) begin
        for (int j = $urandom_range(3, 14); j > 0; j--)
          queue_event(REQ_TIMEOUT, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 95) begin
        queue_event(REQ_TIMEOUT, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        queue_event(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    while (event_q.size() != 0 || report_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MIN_WINDOW: min_win_c = 64'(val[15:0]);
      CFG_MAX_WINDOW: max_win_c = 64'(val[15:0]);
      CFG_MIN_TIMEOUT: min_rto_c = 64'(val);
      CFG_MAX_TIMEOUT: max_rto_c = 64'(val);
      CFG_TIMEOUT_LIMIT: to_limit_c = 64'(val[7:0]);
      CFG_DUPACK_THRESH: dupack_c = 64'(val[6:0]);
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] iw, input logic [31:0] mnw,
                             input logic [31:0] mxw, input logic [31:0] ito,
                             input logic [31:0] mnt, input logic [31:0] mxt,
                             input logic [31:0] lim, input logic [31:0] dup);
    write_reg(CFG_INITIAL_WINDOW, iw);
    write_reg(CFG_MIN_WINDOW, mnw);
    write_reg(CFG_MAX_WINDOW, mxw);
    write_reg(CFG_INITIAL_TIMEOUT, ito);
    write_reg(CFG_MIN_TIMEOUT, mnt);
    write_reg(CFG_MAX_TIMEOUT, mxt);
    write_reg(CFG_TIMEOUT_LIMIT, lim);
    write_reg(CFG_DUPACK_THRESH, dup);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    event_t hold;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, estimator seeding, ack saturation, fast retransmit, peer loss
    queue_event(REQ_ACK, 0, 0, 0, 0, 0);
    queue_event(REQ_RTT, 0, 0, 0, 0, 0);
    queue_event(REQ_RTT, 32'hffff_ffff, 0, 0, 0, 0);
    queue_event(REQ_RTT, 1, 0, 0, 0, 0);
    queue_event(REQ_RTT, 100000, 0, 0, 0, 0);
    queue_event(REQ_ACK, 0, 1024, 0, 0, 0);
    queue_event(REQ_ACK, 0, 32'h7ff, 32'h7f, 1, 32'hffff_ffff);
    queue_event(REQ_ACK, 0, 5, 2, 1, 32'hffff_ffff);
    queue_event(REQ_ACK, 0, 5, 32'h7f, 1, 0);
    queue_event(REQ_ACK, 0, 5, 32'h7f, 0, 32'hffff_ffff);
    queue_event(REQ_NONE, 32'hffff_ffff, 32'h7ff, 32'h7f, 1, 32'hffff_ffff);
    for (int i = 0; i < 12; i++) queue_event(REQ_TIMEOUT, 0, 0, 0, 0, 0);
    queue_event(REQ_ACK, 0, 1, 0, 0, 0);
    wait_idle();

    // random phases over a range of settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      tx_idle_on = ph[0];
      rx_idle_on = ph[1] ^ ph[2];
      case (ph)
        1: load_config(1, 1, 1, 1, 1, 1, 0, 1);
        2: load_config(32'hffff, 32'hffff, 32'hffff, 32'hffff_ffff, 32'hffff_ffff,
                       32'hffff_ffff, 32'hff, 64);
        3: load_config(3, 32'hffff, 1, 5, 32'hffff_ffff, 1, 1, 64);
        4: load_config(10, 2, 64, 1000, 1000, 5000000, 3, 2);
        5: load_config($urandom, $urandom_range(1, 8), $urandom_range(8, 512),
                       $urandom, $urandom_range(1, 500000), $urandom, $urandom_range(0, 20),
                       $urandom_range(1, 64));
        6: load_config(1, 1, 32'hffff, 1, 1, 32'hffff_ffff, 32'hff, 1);
        7: load_config(32'(RST_INITIAL_WINDOW), 32'(RST_MIN_WINDOW), 32'(RST_MAX_WINDOW),
                       RST_INITIAL_TIMEOUT, RST_MIN_TIMEOUT, RST_MAX_TIMEOUT,
                       32'(RST_TIMEOUT_LIMIT), 32'(RST_DUPACK_THRESH));
        default: ;
      endcase
      queue_random(40);
      // sender holds off until everything owed so far has come back
      hold = event_q[event_q.size() - 1];
      hold.drain = 1'b1;
      event_q.insert(event_q.size(), hold);
      queue_random(35);
      wait_idle();
    end

    $display("covered %0d rtt samples, %0d ack reports, %0d timeouts, %0d unknown",
             n_rtt, n_ack, n_tmo, n_none);
    $display("%0d reports checked, %0d fast retransmits, %0d peer-lost flags",
             n_reports, n_fr, n_lost);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cwrc_pkg.sv
hw/rtl/cwrc_front.sv
hw/rtl/cwrc_queue.sv
hw/rtl/cwrc_recip.sv
hw/rtl/cwrc_back.sv
hw/rtl/congestion_window_rto_controller.sv
hw/rtl/cwrc_checker.sv
test/tb.sv
